FILE: rtl/range_frame_sync_parser_macros.svh
// ----------------------------------------------------------------------------
// Range frame sync parser assertion macros
// Shared property wrappers for the checker, clocked with reset disable.
// ----------------------------------------------------------------------------
`ifndef RANGE_FRAME_SYNC_PARSER_MACROS_SVH
`define RANGE_FRAME_SYNC_PARSER_MACROS_SVH

// same-cycle implication
`define RFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rfs_pkg.sv
// ----------------------------------------------------------------------------
// Range frame sync parser package
// Frame constants and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rfs_pkg;

	localparam int unsigned FRAME_BYTES_DEF = 9;
	localparam logic [7:0]  HDR_BYTE        = 8'h59;

	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_CSUM = 1'b1
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/range_frame_sync_parser.sv
// After accept the parser scans and returns to idle when no frame completes; a dropped byte
// keeps it scanning. A full frame: accept, scan, a pass through the shared adder over the
// first FRAME_BYTES-1 bytes, check and emit; a checksum miss adds a rescan of up to
// FRAME_BYTES-3 single-byte drops and a closing scan, and an output stall adds its own
// wait; in_stall stays high meanwhile.
// Reset (arst_n low, asynchronous): buffer empty, no result pending.
// ----------------------------------------------------------------------------
// Range frame sync parser
// Header hunt, additive checksum and distance extraction on a byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module range_frame_sync_parser
	import rfs_pkg::*;
#(
	parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      range_cm,
	output logic             frame_status
);

	localparam int unsigned IDXW  = $clog2(FRAME_BYTES);
	localparam int unsigned FILLW = $clog2(FRAME_BYTES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SUM,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [FILLW-1:0] fill_q;
	logic [IDXW-1:0]  idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       buf_q [FRAME_BYTES];
	logic [15:0]      res_dist_q;
	status_t          res_status_q;
	logic             out_valid_q;
	logic [15:0]      distance_q;
	status_t          status_q;

	logic accept;
	logic hdr_pair;
	logic scan_drop;
	logic csum_ok;
	logic emit_go;
	logic shift_en;

	assign in_stall     = (state_q != ST_IDLE);
	assign accept       = in_valid && !in_stall;
	assign hdr_pair     = (buf_q[0] == HDR_BYTE) && (buf_q[1] == HDR_BYTE);
	assign scan_drop    = (fill_q >= FILLW'(2)) && !hdr_pair;
	assign csum_ok      = (sum_q == buf_q[FRAME_BYTES-1]);
	assign emit_go      = !out_valid_q || !out_stall;
	assign shift_en     = ((state_q == ST_SCAN) && scan_drop) ||
	                      ((state_q == ST_CHECK) && !csum_ok) ||
	                      ((state_q == ST_EMIT) && emit_go && (res_status_q == STATUS_CSUM));

	assign out_valid    = out_valid_q;
	assign range_cm     = distance_q;
	assign frame_status = status_q;

	// byte store: append at fill position, drop front by shifting
	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q[fill_q[IDXW-1:0]] <= rx_byte;
		end else if (shift_en) begin
			for (int k = 0; k < FRAME_BYTES - 1; k++) begin
				buf_q[k] <= buf_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			idx_q        <= '0;
			sum_q        <= '0;
			res_dist_q   <= '0;
			res_status_q <= STATUS_OK;
			out_valid_q  <= 1'b0;
			distance_q   <= '0;
			status_q     <= STATUS_OK;
		end else begin
			if ((state_q == ST_EMIT) && emit_go) begin
				out_valid_q <= 1'b1;
				distance_q  <= res_dist_q;
				status_q    <= res_status_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q  <= fill_q + FILLW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_drop) begin
						fill_q <= fill_q - FILLW'(1);
					end else if (fill_q == FILLW'(FRAME_BYTES)) begin
						idx_q   <= '0;
						sum_q   <= '0;
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM: begin
					sum_q <= sum_q + buf_q[idx_q];
					idx_q <= idx_q + IDXW'(1);
					if (idx_q == IDXW'(FRAME_BYTES - 2)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (csum_ok) begin
						res_dist_q   <= {buf_q[3], buf_q[2]};
						res_status_q <= STATUS_OK;
						fill_q       <= '0;
					end else begin
						res_dist_q   <= '0;
						res_status_q <= STATUS_CSUM;
						fill_q       <= fill_q - FILLW'(1);
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (res_status_q == STATUS_CSUM) begin
							fill_q  <= fill_q - FILLW'(1);
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rfs_checker.sv
// ----------------------------------------------------------------------------
// Range frame sync parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_frame_sync_parser_macros.svh"

module rfs_checker
	import rfs_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] range_cm,
	input wire logic        frame_status
);

	logic        in_beat;
	logic        out_wait;
	logic        err_beat;
	logic [16:0] out_word;

	assign in_beat  = in_valid && !in_stall;
	assign out_wait = out_valid && out_stall;
	assign err_beat = out_valid && (frame_status == STATUS_CSUM);
	assign out_word = {range_cm, frame_status};

	`RFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, out_valid && $stable(out_word), "stalled beat changed")
	`RFS_ASSERT_NOW(a_err_zero, clk, arst_n, err_beat, range_cm == 16'd0, "error beat carries a range")
	`RFS_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_beat, in_stall, "input not stalled while parsing")
	`RFS_ASSERT_NOW(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall), "result without parsing")

endmodule

bind range_frame_sync_parser rfs_checker u_rfs_checker (.*);

`default_nettype wire
